FILE: sv/mexp_pkg.sv
package mexp_pkg;

  // Operand width used unless the top level is given another one
  localparam int WIDTH_DEFAULT = 32;

  // Modulus loaded at reset
  localparam int MOD_RESET = 23;

endpackage

FILE: sv/mexp_if.sv
// Request channel: base and exponent
interface mexp_in_if #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

// Response channel: result
interface mexp_out_if #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

FILE: sv/modular_exponentiation_top.sv
// Modular exponentiation, left-to-right square and multiply.
// in_ch carries a transaction of base and exponent; out_ch returns one
// transaction holding base^exponent mod modulus. Both channels use a
// valid/ready handshake. The modulus is written through cfg_we/cfg_data;
// the user must write it only while the block is idle, which the block
// does not enforce. Values 0 and 1 act as 2. Reset loads 23.
// Every modular multiply runs on one shared shift-and-add unit that does
// one modular add per cycle while it is busy. A transaction needs one
// multiply to reduce the base, WIDTH squarings and one multiply per set
// exponent bit. in_ch.ready is high only when no transaction is in flight;
// the result sits in an output register, so a new transaction is taken
// while the previous result waits. If the receiver stalls, the next result
// holds in the sequencer until the output register frees up. Synchronous
// reset drops any work in flight and clears out_ch.valid.
module modular_exponentiation_top #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  mexp_in_if.sink          in_ch,
  mexp_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [WIDTH-1:0] cfg_data
);

  localparam int CW = $clog2(WIDTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_SQUARE = 3'd2;
  localparam logic [2:0] S_MULT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);
  localparam logic [WIDTH-1:0] TWO = WIDTH'(2);

  logic [2:0]       state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] m_eff;
  logic [WIDTH-1:0] base_r;
  logic [WIDTH-1:0] exp_r;
  logic [WIDTH-1:0] r;
  logic [CW-1:0]    bit_cnt;

  logic             accept;
  logic             last_bit;
  logic             out_free;
  logic             mm_start;
  logic [WIDTH-1:0] mm_a;
  logic [WIDTH-1:0] mm_b;
  logic             mm_done;
  logic [WIDTH-1:0] mm_result;

  // Modulus register; clamp values below two
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(mexp_pkg::MOD_RESET);
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  assign m_eff = (modulus[WIDTH-1:1] == '0) ? TWO : modulus;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_bit    = (bit_cnt == '0);
  assign out_free    = !out_ch.valid || out_ch.ready;

  // Launch the shared multiplier:
  //   accept          -> 1 * base      (reduce the base)
  //   reduce done     -> 1 * 1         (first squaring of r = 1)
  //   square done     -> r * base, or next r * r
  //   multiply done   -> next r * r
  always_comb begin
    mm_start = 1'b0;
    mm_a     = mm_result;
    mm_b     = mm_result;
    unique case (state)
      S_IDLE: begin
        mm_start = accept;
        mm_a     = ONE;
        mm_b     = in_ch.base;
      end
      S_REDUCE: begin
        mm_start = mm_done;
        mm_a     = ONE;
        mm_b     = ONE;
      end
      S_SQUARE: begin
        mm_start = mm_done && (exp_r[WIDTH-1] || !last_bit);
        mm_b     = exp_r[WIDTH-1] ? base_r : mm_result;
      end
      S_MULT: begin
        mm_start = mm_done && !last_bit;
      end
      S_DONE: begin
        mm_start = 1'b0;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  mexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .m      (m_eff),
    .done   (mm_done),
    .result (mm_result)
  );

  // Sequencer: walk the exponent from its top bit down
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (mm_done) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (mm_done) begin
            if (exp_r[WIDTH-1]) begin
              state <= S_MULT;
            end else if (last_bit) begin
              state <= S_DONE;
            end
          end
        end
        S_MULT: begin
          if (mm_done) begin
            state <= last_bit ? S_DONE : S_SQUARE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Operand and exponent registers
  always_ff @(posedge clk) begin
    if (accept) begin
      exp_r   <= in_ch.exponent;
      bit_cnt <= CW'(WIDTH - 1);
    end
    if (state == S_REDUCE && mm_done) begin
      base_r <= mm_result;
    end
    if ((state == S_SQUARE || state == S_MULT) && mm_done) begin
      r <= mm_result;
      // Advance to the next exponent bit once this bit is finished
      if (state == S_MULT || !exp_r[WIDTH-1]) begin
        exp_r   <= {exp_r[WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt - 1'b1;
      end
    end
  end

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_ch.result <= r;
    end
  end

`ifndef ASSERT_OFF
  a_accept_reduce: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_REDUCE)
    else $error("accepted transaction did not start base reduction");
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside the done state");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == S_REDUCE || state == S_SQUARE || state == S_MULT))
    else $error("multiplier finished while the sequencer was not waiting");
`endif

endmodule

FILE: sv/mexp_mulmod.sv
// Shift-and-add modular multiplier: result = (a * b) mod m, a < m.
// One modular add per cycle while busy: doubling and conditional add alternate.
module mexp_mulmod #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] b_r;
  logic [WIDTH-1:0] m_r;
  logic [CW-1:0]    cnt;
  logic             phase;
  logic             busy;

  logic [WIDTH-1:0] opnd;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] add_res;

  // Shared modular adder: acc + opnd, one conditional subtract of m
  always_comb begin
    opnd    = phase ? a_r : acc;
    sum     = {1'b0, acc} + {1'b0, opnd};
    diff    = sum - {1'b0, m_r};
    add_res = (sum >= {1'b0, m_r}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase && cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
      m_r <= m;
      cnt <= CW'(WIDTH - 1);
    end else if (busy) begin
      if (!phase) begin
        acc <= add_res;
      end else begin
        if (b_r[WIDTH-1]) begin
          acc <= add_res;
        end
        b_r <= {b_r[WIDTH-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign result = acc;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while still busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
`endif

endmodule

FILE: sim/tb.sv
module tb;

  localparam int W = mexp_pkg::WIDTH_DEFAULT;

  // Longest run of cycles with no transaction on either channel. A correct
  // run peaks with the slowest exponent followed by the longest receiver
  // stall.
  localparam int WATCHDOG_LIMIT = 40000;

  // Cycles to watch for stray results once nothing is pending.
  localparam int TAIL_CYCLES = 4500;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table. A config row loads opa into the modulus.
  // An item row sends opa as the base and opb as the exponent. When
  // has_want is set, want is the known answer; otherwise the model
  // computes it.
  typedef struct packed {
    row_kind_t    kind;
    logic [W-1:0] opa;
    logic [W-1:0] opb;
    logic         has_want;
    logic [W-1:0] want;
  } plan_row_t;

  // One transaction in flight: its operands and the result it must return.
  typedef struct {
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic [W-1:0] want;
  } power_job_t;

  localparam int PLAN_ROWS = 27;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Reset modulus 23: zero, unit and widest exponents, zero base, base equal
    // to the modulus, and the widest base. 2^32 - 1 is 11 mod 23.
    '{ROW_ITEM, 32'd5,         32'd0,         1'b1, 32'd1},
    '{ROW_ITEM, 32'd5,         32'd1,         1'b1, 32'd5},
    '{ROW_ITEM, 32'hFFFF_FFFF, 32'd1,         1'b1, 32'd11},
    '{ROW_ITEM, 32'd0,         32'd0,         1'b1, 32'd1},
    '{ROW_ITEM, 32'd0,         32'd5,         1'b1, 32'd0},
    '{ROW_ITEM, 32'd23,        32'd3,         1'b1, 32'd0},
    '{ROW_ITEM, 32'd2,         32'hFFFF_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0},
    // A modulus of 0 acts as 2.
    '{ROW_CFG,  32'd0,         32'd0,         1'b0, 32'd0},
    '{ROW_ITEM, 32'd3,         32'd0,         1'b1, 32'd1},
    '{ROW_ITEM, 32'd4,         32'd1,         1'b1, 32'd0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1},
    // So does a modulus of 1.
    '{ROW_CFG,  32'd1,         32'd0,         1'b0, 32'd0},
    '{ROW_ITEM, 32'd7,         32'd2,         1'b1, 32'd1},
    '{ROW_CFG,  32'd2,         32'd0,         1'b0, 32'd0},
    '{ROW_ITEM, 32'd6,         32'd3,         1'b1, 32'd0},
    // Widest modulus: base m-1 behaves as -1.
    '{ROW_CFG,  32'hFFFF_FFFF, 32'd0,         1'b0, 32'd0},
    '{ROW_ITEM, 32'hFFFF_FFFE, 32'd1,         1'b1, 32'hFFFF_FFFE},
    '{ROW_ITEM, 32'hFFFF_FFFF, 32'd1,         1'b1, 32'd0},
    '{ROW_ITEM, 32'hFFFF_FFFE, 32'd2,         1'b1, 32'd1},
    '{ROW_ITEM, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE},
    '{ROW_ITEM, 32'h1234_5678, 32'hDEAD_BEEF, 1'b0, 32'd0},
    '{ROW_ITEM, 32'h89AB_CDEF, 32'd0,         1'b1, 32'd1},
    // Largest 32-bit prime. Fermat gives 2^(p-1) = 1, and 2^32 - 1 is 4.
    '{ROW_CFG,  32'hFFFF_FFFB, 32'd0,         1'b0, 32'd0},
    '{ROW_ITEM, 32'd2,         32'hFFFF_FFFA, 1'b1, 32'd1},
    '{ROW_ITEM, 32'hFFFF_FFFF, 32'd1,         1'b1, 32'd4},
    '{ROW_ITEM, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 32'd0}
  };

  localparam int RANDOM_PHASES  = 5;
  localparam int ITEMS_PER_PHASE = 24;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [W-1:0] cfg_data;

  mexp_in_if  #(.WIDTH(W)) in_ch ();
  mexp_out_if #(.WIDTH(W)) out_ch ();

  modular_exponentiation_top #(.WIDTH(W)) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Modulus as the block holds it, tracked for the model.
  logic [W-1:0] modulus_q = W'(mexp_pkg::MOD_RESET);

  // Results still owed by the block, oldest first.
  power_job_t pending_powers[$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int rx_run = 0;

  // Sender pacing: transactions left in the current burst. When the burst
  // ends, the sender rests for a while.
  int burst_left = 0;
  // Set while in_ch.valid is still high from a transaction that was already
  // taken. The next send overwrites it; anything else must lower it first.
  bit tx_stale = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------

  // Modular product done exactly at double width.
  function automatic logic [W-1:0] mul_mod(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    logic [2*W-1:0] wide_a;
    logic [2*W-1:0] wide_b;
    logic [2*W-1:0] wide_m;
    wide_a = a;
    wide_b = b;
    wide_m = m;
    return W'((wide_a * wide_b) % wide_m);
  endfunction

  // base^exponent mod m. Scan the exponent from the top bit down, the same
  // way the hardware does; a modulus below 2 counts as 2.
  function automatic logic [W-1:0] predict_power(logic [W-1:0] base,
                                                 logic [W-1:0] exponent,
                                                 logic [W-1:0] modulus);
    logic [W-1:0] m;
    logic [W-1:0] base_r;
    logic [W-1:0] acc;
    m      = (modulus < 2) ? W'(2) : modulus;
    base_r = base % m;
    acc    = W'(1);
    for (int i = W - 1; i >= 0; i--) begin
      acc = mul_mod(acc, acc, m);
      if (exponent[i]) acc = mul_mod(acc, base_r, m);
    end
    return acc;
  endfunction

  // ---------------------------------------------------------------------
  // Random operands
  // ---------------------------------------------------------------------

  function automatic logic [W-1:0] pick_modulus(int phase);
    case (phase)
      0:       return $urandom() | 32'h8000_0001;  // large odd
      1:       return $urandom_range(0, 64);       // small, may clamp
      2:       return 32'h8000_0000;
      3:       return $urandom();
      default: return $urandom_range(0, 3);        // clamp region
    endcase
  endfunction

  function automatic logic [W-1:0] pick_base();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return modulus_q - 1;
      3:       return modulus_q;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [W-1:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return W'(1);
      2:       return $urandom_range(2, 20);
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Present one transaction, hold it until it is taken, and log the result
  // it owes. Call this at a falling edge; it returns at a falling edge.
  task automatic send(input logic [W-1:0] base, input logic [W-1:0] exponent,
                      input logic has_want, input logic [W-1:0] want);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.base     <= base;
    in_ch.exponent <= exponent;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    pending_powers.push_back('{base, exponent,
        has_want ? want : predict_power(base, exponent, modulus_q)});
    @(negedge clk);
    if (burst_left > 0) begin
      // Stay in the burst: the next send replaces the payload on this edge.
      burst_left--;
      tx_stale = 1'b1;
    end else begin
      // Rest. Now and then the gap is as long as a whole exponentiation,
      // so the block can go idle before the next transaction.
      burst_left = $urandom_range(0, 5);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1500, 4500)
                                        : $urandom_range(1, 40);
      in_ch.valid <= 1'b0;
      tx_stale = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every pending result has arrived.
  task automatic drain();
    if (tx_stale) begin
      in_ch.valid <= 1'b0;
      tx_stale = 1'b0;
    end
    while (pending_powers.size() != 0) @(negedge clk);
  endtask

  // One-cycle register write. Call this only while the block is idle.
  task automatic write_modulus(input logic [W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    modulus_q = value;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: toggle between ready runs and stalls. Long ready runs give
  // stretches with no stall at all, and the rare long stall makes the next
  // result back up inside the block.
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    if (rx_run != 0) begin
      rx_run <= rx_run - 1;
    end else begin
      out_ch.ready <= !out_ch.ready;
      if (out_ch.ready)
        rx_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(500, 5000)
                                              : $urandom_range(0, 25);
      else
        rx_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(2000, 9000)
                                              : $urandom_range(1, 60);
    end
  end

  // ---------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input power_job_t job,
                                 input logic [W-1:0] got);
    $display("mismatch (%s): base %h exponent %h modulus %h result %h expected %h",
             what, job.base, job.exponent, modulus_q, got, job.want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    power_job_t job;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_powers.size() == 0) begin
        job = '{'0, '0, '0};
        report_mismatch("no transaction pending", job, out_ch.result);
      end else begin
        job = pending_powers.pop_front();
        if (out_ch.result !== job.want)
          report_mismatch("wrong value", job, out_ch.result);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[modular_exponentiation_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    // Drive every input from time zero.
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.base     = '0;
    in_ch.exponent = '0;
    out_ch.ready   = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table. The first rows run on the reset modulus.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        drain();
        write_modulus(PLAN[i].opa);
      end else begin
        send(PLAN[i].opa, PLAN[i].opb, PLAN[i].has_want, PLAN[i].want);
      end
    end

    // Random phases, each under its own modulus. Now and then, hold the
    // sender until every pending result has come back.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      write_modulus(pick_modulus(phase));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 14) == 0) drain();
        send(pick_base(), pick_exponent(), 1'b0, '0);
      end
    end

    // Wait for the last results, then watch a while for stray ones.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[modular_exponentiation_top] OK");
    else
      $display("[modular_exponentiation_top] ERROR");
    $finish;
  end

endmodule

FILE: files.f
sv/mexp_pkg.sv
sv/mexp_if.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation_top.sv
sim/tb.sv
